// ===== rtl/core/pif_pkg.sv =====
// ----------------------------------------------------------------------------
// pif_pkg
// Types and constants for the privileged instruction filter.
// ----------------------------------------------------------------------------
package pif_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned KEY_W   = 27;
   localparam int unsigned ALLOW_N = 41;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [1:0]        verdict_type;

   localparam verdict_type VERDICT_ALLOWED  = 2'd0;
   localparam verdict_type VERDICT_BAD_SYS  = 2'd1;
   localparam verdict_type VERDICT_BAD_BASE = 2'd2;

   localparam logic [9:0] SYS_OPC_TOP = 10'd852;

   localparam key_type ALLOW_LIST [ALLOW_N] = '{
      27'h6A85BF1, 27'h6A85BD1, 27'h6A85BE9, 27'h6A85BE1, 27'h6A85BD9,
      27'h6A85BA1, 27'h6A85BA9,
      27'h6A9DA20, 27'h6A9DA21, 27'h6A9D807, 27'h6A9DE82, 27'h6A9DE83,
      27'h6A9DA14, 27'h6A9DA10, 27'h6A9DA16, 27'h6A9DF00, 27'h6A9DF06,
      27'h6A9DF02, 27'h6A9D801,
      27'h6A9C02C, 27'h6A9C02D, 27'h6A9C028, 27'h6A9C029, 27'h6A9C030,
      27'h6A9C031, 27'h6A9C032, 27'h6A9C038, 27'h6A9C039, 27'h6A9C03A,
      27'h6A9C020, 27'h6A9C021, 27'h6A9C000, 27'h6A9C005, 27'h6A9C006,
      27'h6A8DA20, 27'h6A8DA21, 27'h6A8DE82, 27'h6A8DA14, 27'h6A8DA10,
      27'h6A8DA16, 27'h6A8DF00
   };

   localparam word_type ERET_WORD  = 32'hD69F03E0;
   localparam word_type EXACT_WORD = 32'hD503207F;

endpackage

// ===== rtl/core/privileged_instruction_filter_core.sv =====
// ----------------------------------------------------------------------------
// privileged_instruction_filter_core
// Streams AArch64 instruction words and returns one verdict per word.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register after the classifier.
// Throughput: one request per cycle unless rsp_tready stalls the result stage;
//   an empty input stage still takes a request while the result stage stalls.
// Reset: synchronous, clears both stage valid flags; no other state.
module privileged_instruction_filter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] instr_word
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] verdict, [7:2] zero
   output logic        rsp_tlast    // last_out
);
   import pif_pkg::*;

   logic        in_valid_ff, in_valid_in;
   word_type    in_word_ff;
   logic        in_last_ff;
   logic        out_valid_ff, out_valid_in;
   verdict_type out_verdict_ff;
   logic        out_last_ff;
   verdict_type verdict;
   logic        out_load;
   logic        in_load;

   pif_classify u_classify (
      .instr_word (in_word_ff),
      .verdict    (verdict)
   );

   assign out_load     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || out_load;
   assign in_load      = req_tvalid && req_tready;
   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_word_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (out_load) begin
         out_verdict_ff <= verdict;
         out_last_ff    <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_verdict_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_no_reserved_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3))
      else $error("reserved verdict code on result");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_load) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("input stage lost a stalled request");

   a_load_fills_output: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("classified request not presented");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while both stages stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !in_valid_ff))
      else $error("valid flags not cleared by reset");
`endif

endmodule

// ===== rtl/core/pif_classify.sv =====
// ----------------------------------------------------------------------------
// pif_classify
// Classifies one instruction word against the system allow-list and the
// fixed base patterns.
// ----------------------------------------------------------------------------
module pif_classify (
   input  pif_pkg::word_type    instr_word,
   output pif_pkg::verdict_type verdict
);
   import pif_pkg::*;

   logic    sys_class;
   logic    allowed;
   logic    bad_base;
   key_type key;

   assign key       = instr_word[31:5];
   assign sys_class = (instr_word[31:22] == SYS_OPC_TOP) && (instr_word[20:19] != 2'b00);

   always_comb begin
      allowed = 1'b0;
      for (int i = 0; i < ALLOW_N; i++) begin
         if (ALLOW_LIST[i] == key) begin
            allowed = 1'b1;
         end
      end
   end

   always_comb begin
      bad_base = (instr_word == ERET_WORD)
         || (instr_word[9:0] == 10'h3FF && instr_word[31:11] == 21'h1AD3E1)
         || (instr_word[4:0] == 5'h00 && instr_word[31:21] == 11'h6A2)
         || (instr_word[4:0] == 5'h02 && instr_word[31:21] == 11'h6A0)
         || (instr_word[4:0] == 5'h03 && instr_word[31:21] == 11'h6A0)
         || (instr_word[7:0] == 8'h7F && instr_word[31:12] == 20'hD5004)
         || (instr_word[7:0] == 8'h9F && instr_word[31:12] == 20'hD5004)
         || (instr_word[7:0] == 8'hDF && instr_word[31:12] == 20'hD5034)
         || (instr_word[7:0] == 8'hFF && instr_word[31:12] == 20'hD5034)
         || (instr_word == EXACT_WORD);
   end

   always_comb begin
      if (sys_class) begin
         verdict = allowed ? VERDICT_ALLOWED : VERDICT_BAD_SYS;
      end else if (bad_base) begin
         verdict = VERDICT_BAD_BASE;
      end else begin
         verdict = VERDICT_ALLOWED;
      end
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives privileged_instruction_filter_core with instruction words: a directed
// set of edge words and every flagged encoding, then a random mix biased
// towards the allow-list, the system class and near misses of each base
// pattern. Each request's verdict is predicted and checked in order against
// the result stream, with random stalls on both sides, one long receiver
// hold-off and two drain pauses on the sender.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pif_pkg::*;

   localparam int unsigned RANDOM_WORDS = 1500;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned HOLD_AFTER   = 600;
   localparam int unsigned HOLD_CYCLES  = 250;
   localparam int unsigned DRAIN_AT     = 750;

   localparam logic [9:0]  SYSTEM_PREFIX = 10'd852;
   localparam word_type    ERET_PATTERN  = 32'hD69F03E0;
   localparam word_type    HINT_PATTERN  = 32'hD503207F;
   localparam logic [20:0] ERETA_TOP     = 21'h1AD3E1;
   localparam logic [10:0] HLT_TOP       = 11'h6A2;
   localparam logic [10:0] HVC_SMC_TOP   = 11'h6A0;
   localparam logic [19:0] MSR_PSTATE_A  = 20'hD5004;
   localparam logic [19:0] MSR_PSTATE_B  = 20'hD5034;

   localparam key_type PERMITTED_KEYS [41] = '{
      27'h6A85BF1, 27'h6A85BD1, 27'h6A85BE9, 27'h6A85BE1, 27'h6A85BD9,
      27'h6A85BA1, 27'h6A85BA9,
      27'h6A9DA20, 27'h6A9DA21, 27'h6A9D807, 27'h6A9DE82, 27'h6A9DE83,
      27'h6A9DA14, 27'h6A9DA10, 27'h6A9DA16, 27'h6A9DF00, 27'h6A9DF06,
      27'h6A9DF02, 27'h6A9D801,
      27'h6A9C02C, 27'h6A9C02D, 27'h6A9C028, 27'h6A9C029, 27'h6A9C030,
      27'h6A9C031, 27'h6A9C032, 27'h6A9C038, 27'h6A9C039, 27'h6A9C03A,
      27'h6A9C020, 27'h6A9C021, 27'h6A9C000, 27'h6A9C005, 27'h6A9C006,
      27'h6A8DA20, 27'h6A8DA21, 27'h6A8DE82, 27'h6A8DA14, 27'h6A8DA10,
      27'h6A8DA16, 27'h6A8DF00
   };

   typedef enum int unsigned {
      FORM_ERET, FORM_ERETA, FORM_HLT, FORM_HVC, FORM_SMC,
      FORM_MSR_7F, FORM_MSR_9F, FORM_MSR_DF, FORM_MSR_FF, FORM_HINT
   } base_form_type;

   typedef struct packed {
      word_type word;
      logic     last;
      logic     drain_first;
   } word_request_type;

   typedef struct packed {
      verdict_type verdict;
      logic        last;
   } word_verdict_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   word_request_type pending_words [$];
   word_verdict_type expected_verdicts [$];
   word_request_type offered;
   word_verdict_type awaited;

   bit          req_fired;
   bit          rsp_fired;
   int unsigned gap_left;
   int unsigned rsp_wait;
   int unsigned hold_left;
   bit          sender_burst;
   bit          receiver_burst;
   bit          long_hold_done;
   int unsigned checked_count;
   int unsigned failures;
   int unsigned cycle_count;
   int unsigned verdict_tally [3];
   int unsigned last_tally;

   privileged_instruction_filter_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic verdict_type classify_word(input word_type w);
      verdict_type v;
      bit          permitted;
      v = VERDICT_ALLOWED;
      if (w[31:22] == SYSTEM_PREFIX && w[20:19] != 2'b00) begin
         permitted = 1'b0;
         foreach (PERMITTED_KEYS[i])
            if (PERMITTED_KEYS[i] == w[31:5])
               permitted = 1'b1;
         if (!permitted)
            v = VERDICT_BAD_SYS;
      end else if (w == ERET_PATTERN || w == HINT_PATTERN ||
                   (w[9:0] == 10'h3FF && w[31:11] == ERETA_TOP) ||
                   (w[4:0] == 5'h00 && w[31:21] == HLT_TOP) ||
                   (w[4:0] == 5'h02 && w[31:21] == HVC_SMC_TOP) ||
                   (w[4:0] == 5'h03 && w[31:21] == HVC_SMC_TOP) ||
                   ((w[7:0] == 8'h7F || w[7:0] == 8'h9F) && w[31:12] == MSR_PSTATE_A) ||
                   ((w[7:0] == 8'hDF || w[7:0] == 8'hFF) && w[31:12] == MSR_PSTATE_B)) begin
         v = VERDICT_BAD_BASE;
      end
      return v;
   endfunction

   // fill the free bits of each flagged encoding at random
   function automatic word_type base_word(input base_form_type f);
      word_type w;
      w = $urandom;
      case (f)
         FORM_ERET:   w = ERET_PATTERN;
         FORM_ERETA:  w = {ERETA_TOP, w[10], 10'h3FF};
         FORM_HLT:    w = {HLT_TOP, w[20:5], 5'h00};
         FORM_HVC:    w = {HVC_SMC_TOP, w[20:5], 5'h02};
         FORM_SMC:    w = {HVC_SMC_TOP, w[20:5], 5'h03};
         FORM_MSR_7F: w = {MSR_PSTATE_A, w[11:8], 8'h7F};
         FORM_MSR_9F: w = {MSR_PSTATE_A, w[11:8], 8'h9F};
         FORM_MSR_DF: w = {MSR_PSTATE_B, w[11:8], 8'hDF};
         FORM_MSR_FF: w = {MSR_PSTATE_B, w[11:8], 8'hFF};
         default:     w = HINT_PATTERN;
      endcase
      return w;
   endfunction

   function automatic void queue_word(input word_type w, input logic last,
                                      input logic drain_first);
      word_request_type r;
      r.word        = w;
      r.last        = last;
      r.drain_first = drain_first;
      pending_words.push_back(r);
   endfunction

   always @(posedge clock) begin
      req_fired = !reset && req_tvalid && req_tready;
      rsp_fired = !reset && rsp_tvalid && rsp_tready;
      if (rsp_fired) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result: verdict %0d last_out %0b", rsp_tdata[1:0], rsp_tlast);
            failures++;
         end else begin
            awaited = expected_verdicts.pop_front();
            checked_count++;
            if (rsp_tdata[1:0] !== awaited.verdict) begin
               $error("verdict: expected %0d, actual %0d", awaited.verdict, rsp_tdata[1:0]);
               failures++;
            end
            if (rsp_tlast !== awaited.last) begin
               $error("last_out: expected %0b, actual %0b", awaited.last, rsp_tlast);
               failures++;
            end
            if (rsp_tdata[7:2] !== 6'd0) begin
               $error("padding: expected 0, actual %0h", rsp_tdata[7:2]);
               failures++;
            end
         end
      end
      if (req_fired) begin
         awaited.verdict = classify_word(req_tdata);
         awaited.last    = req_tlast;
         expected_verdicts.push_back(awaited);
         verdict_tally[awaited.verdict]++;
         last_tally += req_tlast;
      end
   end

   // hold each request until taken, then wait out its gap
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0 &&
                      !(pending_words[0].drain_first && expected_verdicts.size() != 0)) begin
            offered = pending_words.pop_front();
            req_tdata  <= offered.word;
            req_tlast  <= offered.last;
            req_tvalid <= 1'b1;
            gap_left = sender_burst ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 63) == 0)
               sender_burst = !sender_burst;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fired) begin
            rsp_wait = receiver_burst ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 63) == 0)
               receiver_burst = !receiver_burst;
            if (!long_hold_done && checked_count >= HOLD_AFTER) begin
               hold_left      = HOLD_CYCLES;
               long_hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      word_type    w;
      int unsigned pick;
      int unsigned form_idx;

      // directed: extremes, every flagged form, class boundaries, near misses
      queue_word(32'h0000_0000, 1'b0, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
      for (int f = FORM_ERET; f <= FORM_HINT; f++)
         queue_word(base_word(base_form_type'(f)), f[0], 1'b0);
      queue_word(32'hD500_0000, 1'b0, 1'b0);
      queue_word({PERMITTED_KEYS[0], 5'h1F}, 1'b0, 1'b0);
      queue_word({PERMITTED_KEYS[40], 5'h00}, 1'b1, 1'b0);
      queue_word(32'hD53F_FFFF, 1'b0, 1'b0);
      queue_word(32'hD508_0000, 1'b0, 1'b0);
      queue_word(ERET_PATTERN ^ 32'h1, 1'b0, 1'b0);
      queue_word({HLT_TOP, 16'hFFFF, 5'h01}, 1'b0, 1'b0);
      queue_word({MSR_PSTATE_A, 4'hF, 8'h5F}, 1'b1, 1'b0);

      for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(0, 99);
         w    = $urandom;
         if (pick < 25) begin
            w = {PERMITTED_KEYS[$urandom_range(0, 40)], w[4:0]};
         end else if (pick < 35) begin
            w = {PERMITTED_KEYS[$urandom_range(0, 40)], w[4:0]};
            w[$urandom_range(5, 31)] ^= 1'b1;
         end else if (pick < 45) begin
            w[31:22] = SYSTEM_PREFIX;
            if (w[20:19] == 2'b00)
               w[19] = 1'b1;
         end else if (pick < 52) begin
            w[31:22] = SYSTEM_PREFIX;
            w[20:19] = 2'b00;
         end else if (pick < 72) begin
            form_idx = $urandom_range(FORM_ERET, FORM_HINT);
            w = base_word(base_form_type'(form_idx));
         end else if (pick < 82) begin
            form_idx = $urandom_range(FORM_ERET, FORM_HINT);
            w = base_word(base_form_type'(form_idx));
            w[$urandom_range(0, 31)] ^= 1'b1;
         end
         queue_word(w, $urandom_range(0, 15) == 0, n == 0 || n == DRAIN_AT);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Classified %0d words: %0d allowed, %0d bad system, %0d bad base.",
               checked_count, verdict_tally[VERDICT_ALLOWED],
               verdict_tally[VERDICT_BAD_SYS], verdict_tally[VERDICT_BAD_BASE]);
      $display("%0d section ends passed through; long receiver hold-off and drain pause done.",
               last_tally);
      if (failures == 0 && expected_verdicts.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
